// ----- design/mlk_pkg.sv -----
// ----------------------------------------------------------------------------
// mlk_pkg: shared types and constants for the Morse letter keyer
// Payload structs, keyer phase and event codes, letter pattern table.
// ----------------------------------------------------------------------------
package mlk_pkg;

  localparam int TimerBitsDefault = 12;
  localparam int DotMsBits        = 11;
  localparam logic [DotMsBits-1:0] DotMsReset = 11'd100;

  // keyer phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SOUND = 2'd1;
  localparam logic [1:0] PH_GAP   = 2'd2;

  // key events
  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_DOT_START  = 3'd1;
  localparam logic [2:0] EV_DASH_START = 3'd2;
  localparam logic [2:0] EV_DOT_STOP   = 3'd3;
  localparam logic [2:0] EV_DASH_STOP  = 3'd4;

  localparam logic       OP_TICK = 1'b0;
  localparam logic       OP_SEND = 1'b1;

  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_Z = 8'h7A;

  typedef struct packed {
    logic       op;
    logic [7:0] letter;
  } in_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] key_event;
    logic       key_down;
    logic       busy_res;
  } out_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] pattern;
    logic [2:0] first_idx;
  } lookup_t;

  // Sentinel-coded patterns, 'a' through 'z'; 1 = dash.
  function automatic logic [7:0] letter_code(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:  c = 8'd5;
      5'd1:  c = 8'd24;
      5'd2:  c = 8'd26;
      5'd3:  c = 8'd12;
      5'd4:  c = 8'd2;
      5'd5:  c = 8'd18;
      5'd6:  c = 8'd14;
      5'd7:  c = 8'd16;
      5'd8:  c = 8'd4;
      5'd9:  c = 8'd23;
      5'd10: c = 8'd13;
      5'd11: c = 8'd20;
      5'd12: c = 8'd7;
      5'd13: c = 8'd6;
      5'd14: c = 8'd15;
      5'd15: c = 8'd22;
      5'd16: c = 8'd29;
      5'd17: c = 8'd10;
      5'd18: c = 8'd8;
      5'd19: c = 8'd3;
      5'd20: c = 8'd9;
      5'd21: c = 8'd17;
      5'd22: c = 8'd11;
      5'd23: c = 8'd25;
      5'd24: c = 8'd27;
      5'd25: c = 8'd28;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

// ----- design/mlk_lookup.sv -----
// ----------------------------------------------------------------------------
// mlk_lookup: letter to Morse pattern decode
// Range-checks the character, reads the pattern table and finds the sentinel.
// ----------------------------------------------------------------------------
module mlk_lookup (
  input  logic [7:0]       letter,
  output mlk_pkg::lookup_t lkp
);

  logic [4:0] diff;
  logic [7:0] pat;
  logic [2:0] top;

  always_comb begin
    diff = 5'(letter - mlk_pkg::CHAR_A);
    pat  = mlk_pkg::letter_code(diff);
    // highest set bit at or above bit 2 is the sentinel; default leaves one element
    top = 3'd1;
    for (int b = 2; b <= 7; b++) begin
      if (pat[b]) begin
        top = 3'(b);
      end
    end
    lkp.valid     = (letter >= mlk_pkg::CHAR_A) && (letter <= mlk_pkg::CHAR_Z);
    lkp.pattern   = pat;
    lkp.first_idx = top - 3'd1;
  end

endmodule

// ----- design/morse_letter_keyer.sv -----
// ----------------------------------------------------------------------------
// morse_letter_keyer: one-letter Morse code keyer
// Sends a lower-case letter as dots and dashes timed by millisecond ticks.
// ----------------------------------------------------------------------------
//
//  channel | ports                          | carries
//  --------+--------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data    | op (tick/send), letter
//  result  | out_valid, out_ready, out_data | accepted, key_event, key_down,
//          |                                | busy_res
//  config  | cfg_we, cfg_wdata              | dot_ms
//
// One transaction per clock: each input transaction is worked out by short
// logic from the keyer state and loaded into the result register at the
// accepting edge, so its result is offered from the next cycle on.
// in_ready is high whenever the result register is empty or being drained, so
// a stall on the result side holds the input side only while a result waits.
// Reset (synchronous, rst_n low) idles the keyer and sets dot_ms to 100.
// ----------------------------------------------------------------------------
module morse_letter_keyer #(
  parameter int TIMER_BITS = mlk_pkg::TimerBitsDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mlk_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mlk_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [mlk_pkg::DotMsBits-1:0]  cfg_wdata
);

  // compare width covers both the timer and 3 * dot_ms (13 bits)
  localparam int CW = (TIMER_BITS > 13) ? TIMER_BITS : 13;
  localparam logic [CW-1:0]         TMAX_CW = CW'({TIMER_BITS{1'b1}});
  localparam logic [CW-1:0]         LIM     = TMAX_CW - CW'(1);
  localparam logic [TIMER_BITS-1:0] TMAX    = {TIMER_BITS{1'b1}};

  // keyer state
  logic [mlk_pkg::DotMsBits-1:0] dot_ms_r;
  logic [1:0]                    phase_r, phase_nxt;
  logic [7:0]                    pattern_r, pattern_nxt;
  logic [2:0]                    idx_r, idx_nxt;
  logic [TIMER_BITS-1:0]         elapsed_r, elapsed_nxt;

  // result register
  logic          out_valid_r;
  mlk_pkg::out_t out_data_r, out_data_nxt;

  mlk_pkg::lookup_t lkp;

  logic                  in_fire;
  logic [TIMER_BITS-1:0] elapsed_inc;
  logic [CW-1:0]         dot_ext, dash_raw, dot_len, dash_len, cur_len, inc_ext;
  logic                  cur_dash;
  logic [2:0]            idx_dec;
  logic [2:0]            ev;

  mlk_lookup u_lookup (
    .letter (in_data.letter),
    .lkp    (lkp)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    phase_nxt   = phase_r;
    pattern_nxt = pattern_r;
    idx_nxt     = idx_r;
    elapsed_nxt = elapsed_r;
    ev          = mlk_pkg::EV_NONE;

    // element lengths, clamped so the saturating timer still gets past them
    dot_ext  = CW'(dot_ms_r);
    dash_raw = CW'({dot_ms_r, 1'b0}) + dot_ext;
    dot_len  = (dot_ext > LIM) ? LIM : dot_ext;
    dash_len = (dash_raw > LIM) ? LIM : dash_raw;

    elapsed_inc = (elapsed_r < TMAX) ? elapsed_r + TIMER_BITS'(1) : elapsed_r;
    inc_ext     = CW'(elapsed_inc);
    cur_dash    = pattern_r[idx_r];
    cur_len     = cur_dash ? dash_len : dot_len;
    idx_dec     = idx_r - 3'd1;

    if (in_data.op == mlk_pkg::OP_SEND) begin
      // a send always drops whatever was in flight, with no stop event
      phase_nxt   = mlk_pkg::PH_IDLE;
      elapsed_nxt = '0;
      if (lkp.valid) begin
        pattern_nxt = lkp.pattern;
        idx_nxt     = lkp.first_idx;
        phase_nxt   = mlk_pkg::PH_SOUND;
        ev = lkp.pattern[lkp.first_idx] ? mlk_pkg::EV_DASH_START : mlk_pkg::EV_DOT_START;
      end
    end else begin
      case (phase_r)
        mlk_pkg::PH_SOUND: begin
          elapsed_nxt = elapsed_inc;
          if (inc_ext > cur_len) begin
            ev          = cur_dash ? mlk_pkg::EV_DASH_STOP : mlk_pkg::EV_DOT_STOP;
            elapsed_nxt = '0;
            phase_nxt   = (idx_r == 3'd0) ? mlk_pkg::PH_IDLE : mlk_pkg::PH_GAP;
          end
        end
        mlk_pkg::PH_GAP: begin
          elapsed_nxt = elapsed_inc;
          if (inc_ext > dot_len) begin
            // gap over: next element starts on this same tick
            idx_nxt     = idx_dec;
            elapsed_nxt = '0;
            phase_nxt   = mlk_pkg::PH_SOUND;
            ev = pattern_r[idx_dec] ? mlk_pkg::EV_DASH_START : mlk_pkg::EV_DOT_START;
          end
        end
        default: begin
          phase_nxt   = mlk_pkg::PH_IDLE;
          elapsed_nxt = '0;
        end
      endcase
    end

    out_data_nxt.accepted  = (in_data.op == mlk_pkg::OP_SEND) && lkp.valid;
    out_data_nxt.key_event = ev;
    out_data_nxt.key_down  = (phase_nxt == mlk_pkg::PH_SOUND);
    out_data_nxt.busy_res  = (phase_nxt != mlk_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_ms_r    <= mlk_pkg::DotMsReset;
      phase_r     <= mlk_pkg::PH_IDLE;
      pattern_r   <= '0;
      idx_r       <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        dot_ms_r <= cfg_wdata;
      end
      if (in_fire) begin
        phase_r     <= phase_nxt;
        pattern_r   <= pattern_nxt;
        idx_r       <= idx_nxt;
        elapsed_r   <= elapsed_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
